// ----- hdl/nlp_pkg.sv -----
// Package: shared types, character codes and digit helpers for the literal parser.
`timescale 1ns / 1ps
`default_nettype none

package nlp_pkg;

  localparam int ValW   = 24;
  localparam int WideW  = ValW + 4;
  localparam int QDepth = 2;
  localparam int PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW   = $clog2(QDepth + 1);
  localparam int LeadN  = 4;

  localparam logic [ValW-1:0] SAT_MAX   = 24'hFFFFFF;
  localparam logic [4:0]      NOT_DIGIT = 5'd16;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CASE_OFS  = 8'h20;
  localparam logic [7:0] HEX_OFS   = 8'h37;

  typedef enum logic [1:0] {
    KIND_BIN  = 2'd0,
    KIND_DEC  = 2'd1,
    KIND_HEX  = 2'd2,
    KIND_CHAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BASE_2,
    BASE_10,
    BASE_16
  } base_t;

  // Token form, decided by the front end at the token's last character.
  typedef enum logic [2:0] {
    MODE_QUOTED,
    MODE_BAD,
    MODE_PHEX,
    MODE_BIN_SUF,
    MODE_DEC_SUF,
    MODE_HEX_SUF,
    MODE_DEC_PLAIN
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic             lf;
    logic [4:0]       digit;
    logic [ValW-1:0]  acc;
    logic             ok;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LA && c <= CH_LZ) r = c - CASE_OFS;
    return r;
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] u);
    logic [7:0] t;
    t = 8'd0;
    if (u >= CH_ZERO && u <= CH_NINE) t = u - CH_ZERO;
    else if (u >= CH_UA && u <= CH_UF) t = u - HEX_OFS;
    else t = {3'd0, NOT_DIGIT};
    return t[4:0];
  endfunction

  // acc * base + d, clamped at SAT_MAX; multipliers are shifts and adds.
  function automatic logic [ValW-1:0] sat_fold(input logic [ValW-1:0] acc,
                                               input base_t base,
                                               input logic [3:0] d);
    logic [WideW-1:0] a;
    logic [WideW-1:0] w;
    a = {4'd0, acc};
    case (base)
      BASE_2:  w = (a << 1) + {{(WideW-4){1'b0}}, d};
      BASE_10: w = (a << 3) + (a << 1) + {{(WideW-4){1'b0}}, d};
      BASE_16: w = (a << 4) + {{(WideW-4){1'b0}}, d};
      default: w = a;
    endcase
    return (w > {4'd0, SAT_MAX}) ? SAT_MAX : w[ValW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/nlp_front.sv -----
// Front end: takes characters, folds digit accumulators, classifies the token.
`timescale 1ns / 1ps
`default_nettype none

module nlp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [7:0]      char_code,
  input  wire logic            last_of_token,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire nlp_pkg::qstat_t qstat,
  output logic                 push,
  output nlp_pkg::entry_t      push_data
);

  logic [2:0]                   chars_seen;
  logic [7:0]                   leading_chars [nlp_pkg::LeadN];
  logic [nlp_pkg::ValW-1:0]     binary_acc;
  logic [nlp_pkg::ValW-1:0]     decimal_acc;
  logic [nlp_pkg::ValW-1:0]     hex_acc;
  logic [nlp_pkg::ValW-1:0]     prefixed_hex_acc;
  logic [3:0]                   digit_ok_flags;

  logic                         accept;
  logic [2:0]                   len;
  logic [7:0]                   u;
  logic [4:0]                   d;
  logic [7:0]                   lc [nlp_pkg::LeadN];
  logic                         lf;
  logic                         q1, q2, lone_suf, lone_x, phex;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && last_of_token;

  assign u   = nlp_pkg::upcase(char_code);
  assign d   = nlp_pkg::digit_of(u);
  assign len = chars_seen + 3'd1;
  assign lf  = (char_code == nlp_pkg::CH_LF);

  always_comb begin
    for (int i = 0; i < nlp_pkg::LeadN; i++) begin
      lc[i] = leading_chars[i];
    end
    if (chars_seen < 3'(nlp_pkg::LeadN)) lc[chars_seen[1:0]] = char_code;
  end

  always_comb begin
    q1 = (len >= 3'd3) && lc[0] == nlp_pkg::CH_QUOTE && lc[2] == nlp_pkg::CH_QUOTE;
    q2 = (len >= 3'd4) && lc[0] == nlp_pkg::CH_DQUOTE && lc[3] == nlp_pkg::CH_DQUOTE;
    lone_suf = (len == 3'd1) &&
               (u == nlp_pkg::CH_B || u == nlp_pkg::CH_D || u == nlp_pkg::CH_H);
    lone_x = (len == 3'd2) && lc[0] == nlp_pkg::CH_ZERO && u == nlp_pkg::CH_X;
    phex = (len >= 3'd3) && lc[0] == nlp_pkg::CH_ZERO &&
           nlp_pkg::upcase(lc[1]) == nlp_pkg::CH_X;

    push_data.lf    = lf;
    push_data.digit = d;
    push_data.acc   = decimal_acc;
    push_data.ok    = digit_ok_flags[1];
    push_data.mode  = nlp_pkg::MODE_DEC_PLAIN;
    if (q1) begin
      push_data.mode = nlp_pkg::MODE_QUOTED;
      push_data.acc  = {16'd0, lc[1]};
      push_data.ok   = 1'b1;
    end else if (q2) begin
      push_data.mode = nlp_pkg::MODE_QUOTED;
      push_data.acc  = {8'd0, lc[1], lc[2]};
      push_data.ok   = 1'b1;
    end else if (lone_suf || lone_x) begin
      push_data.mode = nlp_pkg::MODE_BAD;
      push_data.ok   = 1'b0;
    end else if (phex) begin
      push_data.mode = nlp_pkg::MODE_PHEX;
      push_data.acc  = prefixed_hex_acc;
      push_data.ok   = digit_ok_flags[3];
    end else if (!lf && u == nlp_pkg::CH_B) begin
      push_data.mode = nlp_pkg::MODE_BIN_SUF;
      push_data.acc  = binary_acc;
      push_data.ok   = digit_ok_flags[0];
    end else if (!lf && u == nlp_pkg::CH_D) begin
      push_data.mode = nlp_pkg::MODE_DEC_SUF;
    end else if (!lf && u == nlp_pkg::CH_H) begin
      push_data.mode = nlp_pkg::MODE_HEX_SUF;
      push_data.acc  = hex_acc;
      push_data.ok   = digit_ok_flags[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      chars_seen       <= 3'd0;
      binary_acc       <= '0;
      decimal_acc      <= '0;
      hex_acc          <= '0;
      prefixed_hex_acc <= '0;
      digit_ok_flags   <= 4'hF;
      for (int i = 0; i < nlp_pkg::LeadN; i++) leading_chars[i] <= 8'd0;
    end else if (accept) begin
      for (int i = 0; i < nlp_pkg::LeadN; i++) leading_chars[i] <= lc[i];
      if (chars_seen < 3'(nlp_pkg::LeadN)) chars_seen <= chars_seen + 3'd1;
      if (d > 5'd1) digit_ok_flags[0] <= 1'b0;
      else binary_acc <= nlp_pkg::sat_fold(binary_acc, nlp_pkg::BASE_2, d[3:0]);
      if (d > 5'd9) digit_ok_flags[1] <= 1'b0;
      else decimal_acc <= nlp_pkg::sat_fold(decimal_acc, nlp_pkg::BASE_10, d[3:0]);
      if (d > 5'd15) digit_ok_flags[2] <= 1'b0;
      else hex_acc <= nlp_pkg::sat_fold(hex_acc, nlp_pkg::BASE_16, d[3:0]);
      if (chars_seen >= 3'd2) begin
        if (d > 5'd15) digit_ok_flags[3] <= 1'b0;
        else prefixed_hex_acc <=
               nlp_pkg::sat_fold(prefixed_hex_acc, nlp_pkg::BASE_16, d[3:0]);
      end
    end
  end

  a_token_restart: assert property (@(posedge clk) disable iff (rst)
    push |=> chars_seen == 3'd0)
    else $error("character count not cleared after token end");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    chars_seen <= 3'(nlp_pkg::LeadN))
    else $error("character count past saturation");

endmodule

`default_nettype wire

// ----- hdl/nlp_queue.sv -----
// Queue: short register queue carrying classified tokens from front to back.
`timescale 1ns / 1ps
`default_nettype none

module nlp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire nlp_pkg::entry_t  push_data,
  input  wire logic             pop,
  output nlp_pkg::entry_t       pop_data,
  output nlp_pkg::qstat_t       qstat
);

  nlp_pkg::entry_t              slots [nlp_pkg::QDepth];
  logic [nlp_pkg::PtrW-1:0]     wr_ptr;
  logic [nlp_pkg::PtrW-1:0]     rd_ptr;
  logic [nlp_pkg::CntW-1:0]     count;

  function automatic logic [nlp_pkg::PtrW-1:0] bump(input logic [nlp_pkg::PtrW-1:0] p);
    return (p == nlp_pkg::PtrW'(nlp_pkg::QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign qstat.full  = (count == nlp_pkg::CntW'(nlp_pkg::QDepth));
  assign qstat.empty = (count == '0);
  assign pop_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + nlp_pkg::CntW'(1);
        2'b01:   count <= count - nlp_pkg::CntW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !pop)
    else $error("read from an empty queue");

endmodule

`default_nettype wire

// ----- hdl/nlp_back.sv -----
// Back end: finishes the last digit fold, picks value and kind, holds the result.
`timescale 1ns / 1ps
`default_nettype none

module nlp_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire nlp_pkg::qstat_t         qstat,
  input  wire nlp_pkg::entry_t         pop_data,
  output logic                         pop,
  output logic [nlp_pkg::ValW-1:0]     parsed_value,
  output logic                         parse_error,
  output logic [1:0]                   literal_kind,
  output logic                         out_valid,
  input  wire logic                    out_stall
);

  logic [nlp_pkg::ValW-1:0] value;
  logic                     err;
  nlp_pkg::kind_t           kind;

  assign pop = !qstat.empty && (!out_valid || !out_stall);

  always_comb begin
    value = pop_data.acc;
    err   = !pop_data.ok;
    kind  = nlp_pkg::KIND_DEC;
    case (pop_data.mode)
      nlp_pkg::MODE_QUOTED: begin
        kind = nlp_pkg::KIND_CHAR;
        err  = 1'b0;
      end
      nlp_pkg::MODE_BAD: begin
        err = 1'b1;
      end
      nlp_pkg::MODE_PHEX: begin
        kind = nlp_pkg::KIND_HEX;
        if (!pop_data.lf) begin
          if (pop_data.digit > 5'd15) err = 1'b1;
          else value = nlp_pkg::sat_fold(pop_data.acc, nlp_pkg::BASE_16,
                                         pop_data.digit[3:0]);
        end
      end
      nlp_pkg::MODE_BIN_SUF: kind = nlp_pkg::KIND_BIN;
      nlp_pkg::MODE_DEC_SUF: kind = nlp_pkg::KIND_DEC;
      nlp_pkg::MODE_HEX_SUF: kind = nlp_pkg::KIND_HEX;
      nlp_pkg::MODE_DEC_PLAIN: begin
        kind = nlp_pkg::KIND_DEC;
        if (!pop_data.lf) begin
          if (pop_data.digit > 5'd9) err = 1'b1;
          else value = nlp_pkg::sat_fold(pop_data.acc, nlp_pkg::BASE_10,
                                         pop_data.digit[3:0]);
        end
      end
      default: err = 1'b1;
    endcase
    if (err) begin
      value = '0;
      kind  = nlp_pkg::KIND_BIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      parsed_value <= value;
      parse_error  <= err;
      literal_kind <= kind;
    end
  end

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && parse_error) |->
      (parsed_value == '0 && literal_kind == 2'(nlp_pkg::KIND_BIN)))
    else $error("error result carries a value or kind");

endmodule

`default_nettype wire

// ----- hdl/numeric_literal_parser.sv -----
// Top level: numeric literal parser with decoupled front end, queue and back end.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------
//   in      | in_valid  | in_stall  | char_code[7:0], last_of_token
//   out     | out_valid | out_stall | parsed_value[23:0], parse_error,
//           |           |           | literal_kind[1:0]
//
// One character request is taken every cycle while in_stall is low; the front
// end folds the digit accumulators in the cycle a non-final character is
// accepted (prefixed hex from the third character on). A token's result goes
// through the two-entry queue, then the back end output register, to out_valid.
// in_stall rises only when the queue is full, i.e. two finished tokens wait
// behind a stalled output; characters that do not end a token still stop then.
// Reset (rst, synchronous) clears the token state and the queue.
`timescale 1ns / 1ps
`default_nettype none

module numeric_literal_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  char_code,
  input  wire logic        last_of_token,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic [23:0]      parsed_value,
  output logic             parse_error,
  output logic [1:0]       literal_kind,
  output logic             out_valid,
  input  wire logic        out_stall
);

  // Queue status and the request carried from front to back.
  nlp_pkg::qstat_t qstat;
  nlp_pkg::entry_t push_data;
  nlp_pkg::entry_t pop_data;
  logic            push;
  logic            pop;

  // Front: accept characters, classify the token at its last character.
  nlp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .char_code     (char_code),
    .last_of_token (last_of_token),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .qstat         (qstat),
    .push          (push),
    .push_data     (push_data)
  );

  // Queue: hold finished tokens so either side can stall on its own.
  nlp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  // Back: final digit fold, error masking, registered result.
  nlp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .pop_data     (pop_data),
    .pop          (pop),
    .parsed_value (parsed_value),
    .parse_error  (parse_error),
    .literal_kind (literal_kind),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench top: drives character tokens into the numeric literal parser and checks each result.
`timescale 1ns / 1ps

module tb_top;
  import nlp_pkg::*;

  localparam int unsigned VAL_MAX      = 24'hFFFFFF;
  localparam int unsigned NO_DIGIT     = 16;
  localparam int          RANDOM_CHARS = 750;
  localparam int          MAX_WAIT     = 10;
  localparam int          IDLE_LIMIT   = 300;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          MAX_REPORTS  = 40;

  // Bit positions in the digit-validity flags.
  localparam int OK_BIN = 0;
  localparam int OK_DEC = 1;
  localparam int OK_HEX = 2;
  localparam int OK_PFX = 3;

  typedef struct packed {
    logic [23:0] value;
    logic        err;
    kind_t       kind;
  } literal_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    literal_t   want;
  } stim_row_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic [7:0]  char_code     = 8'd0;
  logic        last_of_token = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [23:0] parsed_value;
  logic        parse_error;
  logic [1:0]  literal_kind;
  logic        out_valid;
  logic        out_stall     = 1'b0;

  numeric_literal_parser dut (
    .clk           (clk),
    .rst           (rst),
    .char_code     (char_code),
    .last_of_token (last_of_token),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .parsed_value  (parsed_value),
    .parse_error   (parse_error),
    .literal_kind  (literal_kind),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Token state of the predictor: what the parser has folded so far.
  logic [2:0]  tok_pos;
  logic [7:0]  head [4];
  int unsigned acc_bin;
  int unsigned acc_dec;
  int unsigned acc_hex;
  int unsigned acc_pfx;
  logic [3:0]  digits_ok;

  literal_t    pending_q [$];   // predicted literals, oldest first
  stim_row_t   dir_rows [$];
  logic [7:0]  tok_chars [$];

  // While calm is set, neither side inserts gaps or stalls.
  logic        calm = 1'b0;
  int          hold_left = 0;
  int          out_wait;
  int          quiet_cycles = 0;
  int          n_fail = 0;
  int          n_dir_chars = 0;
  int          n_rand_chars = 0;
  int          n_checked = 0;
  int          n_err_seen = 0;
  int          kind_seen [4] = '{0, 0, 0, 0};

  function void clear_token();
    tok_pos   = 3'd0;
    head      = '{8'd0, 8'd0, 8'd0, 8'd0};
    acc_bin   = 0;
    acc_dec   = 0;
    acc_hex   = 0;
    acc_pfx   = 0;
    digits_ok = 4'b1111;
  endfunction

  // acc * base + d, clamped to the 24-bit ceiling.
  function int unsigned fold_sat(input int unsigned acc, input int unsigned base,
                                 input int unsigned d);
    longint unsigned w;
    w = acc;
    w = w * base + d;
    return (w > VAL_MAX) ? VAL_MAX : w[31:0];
  endfunction

  function logic [7:0] to_upper(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) ? (c ^ CASE_OFS) : c;
  endfunction

  function int unsigned digit_val(input logic [7:0] u);
    if (u >= CH_ZERO && u <= CH_NINE) return u - CH_ZERO;
    if (u >= CH_UA && u <= CH_UF) return u - CH_UA + 10;
    return NO_DIGIT;
  endfunction

  // Fold one non-final character into every accumulator; the prefixed-hex
  // accumulator starts at the third character.
  function void fold_digit(input int unsigned d, input int unsigned pos);
    if (d > 1) digits_ok[OK_BIN] = 1'b0;
    else acc_bin = fold_sat(acc_bin, 2, d);
    if (d > 9) digits_ok[OK_DEC] = 1'b0;
    else acc_dec = fold_sat(acc_dec, 10, d);
    if (d > 15) digits_ok[OK_HEX] = 1'b0;
    else acc_hex = fold_sat(acc_hex, 16, d);
    if (pos >= 2) begin
      if (d > 15) digits_ok[OK_PFX] = 1'b0;
      else acc_pfx = fold_sat(acc_pfx, 16, d);
    end
  endfunction

  // Advance the predictor by one accepted character; return 1 with the
  // literal in lit when the character ends the token.
  function bit predict_char(input logic [7:0] c, input logic last, output literal_t lit);
    int unsigned pos;
    int unsigned len;
    int unsigned d;
    int unsigned value;
    logic [7:0]  u;
    logic        lf;
    logic        err;
    kind_t       kind;
    pos   = tok_pos;
    value = 0;
    err   = 1'b0;
    kind  = KIND_BIN;
    lit   = '0;
    if (pos < 4) head[pos] = c;
    u = to_upper(c);
    d = digit_val(u);
    if (!last) begin
      fold_digit(d, pos);
      if (pos < 4) tok_pos = pos + 1;
      return 1'b0;
    end
    len = pos + 1;
    lf  = (c == CH_LF);
    // Quoted forms win over everything, on raw bytes.
    if (len >= 3 && head[0] == CH_QUOTE && head[2] == CH_QUOTE) begin
      value = head[1];
      kind  = KIND_CHAR;
    end else if (len >= 4 && head[0] == CH_DQUOTE && head[3] == CH_DQUOTE) begin
      value = {head[1], head[2]};
      kind  = KIND_CHAR;
    end else if (len == 1 && (u == CH_B || u == CH_D || u == CH_H)) begin
      err = 1'b1;
    end else if (len == 2 && head[0] == CH_ZERO && u == CH_X) begin
      err = 1'b1;
    end else if (len >= 3 && head[0] == CH_ZERO && to_upper(head[1]) == CH_X) begin
      kind  = KIND_HEX;
      value = acc_pfx;
      err   = !digits_ok[OK_PFX];
      if (!lf) begin
        if (d > 15) err = 1'b1;
        else value = fold_sat(value, 16, d);
      end
    end else if (!lf && u == CH_B) begin
      value = acc_bin;
      err   = !digits_ok[OK_BIN];
    end else if (!lf && u == CH_D) begin
      kind  = KIND_DEC;
      value = acc_dec;
      err   = !digits_ok[OK_DEC];
    end else if (!lf && u == CH_H) begin
      kind  = KIND_HEX;
      value = acc_hex;
      err   = !digits_ok[OK_HEX];
    end else begin
      // Plain decimal; a trailing line feed is dropped, not folded.
      kind  = KIND_DEC;
      value = acc_dec;
      err   = !digits_ok[OK_DEC];
      if (!lf) begin
        if (d > 9) err = 1'b1;
        else value = fold_sat(value, 10, d);
      end
    end
    if (err) begin
      value = 0;
      kind  = KIND_BIN;
    end
    lit.value = value[23:0];
    lit.err   = err;
    lit.kind  = kind;
    clear_token();
    return 1'b1;
  endfunction

  task add_row(input logic [7:0] ch, input logic last, input logic typed,
               input logic [23:0] value, input logic err, input kind_t kind);
    stim_row_t row;
    row.ch         = ch;
    row.last       = last;
    row.typed      = typed;
    row.want.value = value;
    row.want.err   = err;
    row.want.kind  = kind;
    dir_rows.push_back(row);
  endtask

  function logic [7:0] digit_char(input int unsigned base);
    int unsigned v;
    v = $urandom_range(0, base - 1);
    if (v < 10) return CH_ZERO + v;
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 10;
  endfunction

  function logic [7:0] any_case(input logic [7:0] letter);
    return $urandom_range(0, 1) ? letter : (letter + CASE_OFS);
  endfunction

  function logic [7:0] suffix_of(input int unsigned base);
    if (base == 2) return any_case(CH_B);
    if (base == 10) return any_case(CH_D);
    return any_case(CH_H);
  endfunction

  // Build one random token in tok_chars: mostly well-formed literals with
  // random digits, some bare markers, some corrupted, some pure noise.
  task build_token();
    int          shape;
    int          n;
    int unsigned base;
    shape = $urandom_range(0, 99);
    n     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
    base  = ($urandom_range(0, 2) == 0) ? 2 : ($urandom_range(0, 1) ? 10 : 16);
    tok_chars.delete();
    if (shape < 8) begin
      tok_chars.push_back(CH_QUOTE);
      tok_chars.push_back($urandom_range(0, 255));
      tok_chars.push_back(CH_QUOTE);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) tok_chars.push_back($urandom_range(0, 255));
    end else if (shape < 15) begin
      tok_chars.push_back(CH_DQUOTE);
      tok_chars.push_back($urandom_range(0, 255));
      tok_chars.push_back($urandom_range(0, 255));
      tok_chars.push_back(CH_DQUOTE);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) tok_chars.push_back($urandom_range(0, 255));
    end else if (shape < 30) begin
      tok_chars.push_back(CH_ZERO);
      tok_chars.push_back(any_case(CH_X));
      repeat (n) tok_chars.push_back(digit_char(16));
      if ($urandom_range(0, 4) == 0) tok_chars.push_back(CH_LF);
    end else if (shape < 70) begin
      if ($urandom_range(0, 7) != 0)
        repeat (n) tok_chars.push_back(digit_char(base));
      tok_chars.push_back(suffix_of(base));
      if ($urandom_range(0, 5) == 0) tok_chars.push_back(CH_LF);
    end else if (shape < 85) begin
      repeat (n) tok_chars.push_back(digit_char(10));
      if ($urandom_range(0, 4) == 0) tok_chars.push_back(CH_LF);
    end else if (shape < 90) begin
      case ($urandom_range(0, 2))
        0: tok_chars.push_back(suffix_of(base));
        1: begin
          tok_chars.push_back(CH_ZERO);
          tok_chars.push_back(any_case(CH_X));
        end
        default: tok_chars.push_back(CH_LF);
      endcase
    end else begin
      repeat ($urandom_range(1, 6)) tok_chars.push_back($urandom_range(0, 255));
    end
    // Break a well-formed number now and then with a stray byte.
    if (shape >= 15 && shape < 85 && $urandom_range(0, 9) == 0)
      tok_chars[$urandom_range(0, tok_chars.size() - 1)] = $urandom_range(0, 255);
  endtask

  // Offer one character request after a random gap, hold it until taken,
  // then record the literal it completes, if any.
  task send_char(input logic [7:0] c, input logic last, input logic typed,
                 input literal_t want);
    int       gap;
    literal_t lit;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    char_code     <= c;
    last_of_token <= last;
    do @(posedge clk); while (in_stall);
    if (predict_char(c, last, lit)) pending_q.push_back(typed ? want : lit);
  endtask

  task report_miss(input string field, input int unsigned want, input int unsigned got);
    if (n_fail < MAX_REPORTS)
      $display("%0t ns: %s expected %0h, actual %0h", $time, field, want, got);
    n_fail++;
  endtask

  // Result side: check every accepted result against the oldest prediction,
  // then, unless calm is set, may raise out_stall for a random hold before taking the next one.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (parse_error) n_err_seen++;
        kind_seen[literal_kind]++;
        if (pending_q.size() == 0) begin
          if (n_fail < MAX_REPORTS)
            $display("%0t ns: result %0h/%0b/%0d with no token pending", $time,
                     parsed_value, parse_error, literal_kind);
          n_fail++;
        end else begin
          if (parsed_value !== pending_q[0].value)
            report_miss("parsed_value", pending_q[0].value, parsed_value);
          if (parse_error !== pending_q[0].err)
            report_miss("parse_error", pending_q[0].err, parse_error);
          if (literal_kind !== pending_q[0].kind)
            report_miss("literal_kind", pending_q[0].kind, literal_kind);
          void'(pending_q.pop_front());
        end
        out_wait = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (out_wait != 0) begin
          out_stall <= 1'b1;
          hold_left <= out_wait;
        end
      end else if (out_stall) begin
        if (hold_left <= 1) out_stall <= 1'b0;
        hold_left <= hold_left - 1;
      end
    end
  end

  // Watchdog: end the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no request moved for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, pending_q.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    clear_token();

    // Directed table. Typed rows carry results that follow directly from the
    // token's form; the rest go through the predictor.
    // Lone suffix letter.
    add_row(CH_B, 1'b1, 1'b1, 24'd0, 1'b1, KIND_BIN);
    // A line feed alone leaves an empty decimal.
    add_row(CH_LF, 1'b1, 1'b1, 24'd0, 1'b0, KIND_DEC);
    // Lone 0x prefix.
    add_row(CH_ZERO, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_X + CASE_OFS, 1'b1, 1'b1, 24'd0, 1'b1, KIND_BIN);
    // Single-quoted top byte.
    add_row(CH_QUOTE, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(8'hFF, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_QUOTE, 1'b1, 1'b1, 24'h0000FF, 1'b0, KIND_CHAR);
    // Double-quoted pair with a zero low byte.
    add_row(CH_DQUOTE, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(8'hFF, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(8'h00, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_DQUOTE, 1'b1, 1'b1, 24'h00FF00, 1'b0, KIND_CHAR);
    // Binary with a lowercase suffix.
    add_row(CH_ZERO + 1, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_ZERO, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_ZERO + 1, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_B + CASE_OFS, 1'b1, 1'b0, 24'd0, 1'b0, KIND_BIN);
    // Prefixed hex, mixed case.
    add_row(CH_ZERO, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_X, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_UF + CASE_OFS, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_UF, 1'b1, 1'b0, 24'd0, 1'b0, KIND_BIN);
    // Bad digit at the end of a plain decimal.
    add_row(CH_NINE, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_LZ - CASE_OFS, 1'b1, 1'b1, 24'd0, 1'b1, KIND_BIN);
    // Decimal closed by a line feed.
    add_row(CH_ZERO + 4, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_ZERO + 2, 1'b0, 1'b0, 24'd0, 1'b0, KIND_BIN);
    add_row(CH_LF, 1'b1, 1'b0, 24'd0, 1'b0, KIND_BIN);

    // Hold reset at the start, then release it for good.
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
      n_dir_chars++;
    end

    // Random tokens; about one in six runs with no gaps and no stalls.
    while (n_rand_chars < RANDOM_CHARS) begin
      build_token();
      calm = ($urandom_range(0, 5) == 0);
      foreach (tok_chars[i])
        send_char(tok_chars[i], i == tok_chars.size() - 1, 1'b0, '0);
      n_rand_chars += tok_chars.size();
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Drain: wait for every predicted literal, then watch for strays.
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d directed and %0d random characters; checked %0d literals.",
             n_dir_chars, n_rand_chars, n_checked);
    $display("Kinds seen: %0d binary, %0d decimal, %0d hex, %0d quoted; %0d flagged bad.",
             kind_seen[KIND_BIN], kind_seen[KIND_DEC], kind_seen[KIND_HEX],
             kind_seen[KIND_CHAR], n_err_seen);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/nlp_pkg.sv
hdl/nlp_front.sv
hdl/nlp_queue.sv
hdl/nlp_back.sv
hdl/numeric_literal_parser.sv
tb/sv/tb_top.sv
